[sv/pft_pkg.sv]
// ============================================================================
// pft_pkg: shared types and constants for the protobuf field tokenizer
// Holds the parse phases, event and error codes, and the per-byte result.
// ============================================================================
package pft_pkg;

    localparam int MSG_LEN_BITS = 16;
    localparam int ACC_W        = 64;
    localparam int IDX_W        = 4;
    localparam int FIELD_W      = 29;
    localparam int WIRE_W       = 3;

    localparam logic [IDX_W-1:0]  IDX_LAST     = 4'd9;
    localparam logic [WIRE_W-1:0] WIRE_VARINT  = 3'd0;
    localparam logic [WIRE_W-1:0] WIRE_LEN     = 3'd2;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_VARINT  = 3'd1,
        EV_HEADER  = 3'd2,
        EV_PAYLOAD = 3'd3,
        EV_ERROR   = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNC     = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_NONCANON  = 3'd3,
        ERR_BAD_TAG   = 3'd4,
        ERR_BAD_LEN   = 3'd5,
        ERR_BAD_WIRE  = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        VS_MORE     = 2'd0,
        VS_DONE     = 2'd1,
        VS_OVERFLOW = 2'd2,
        VS_NONCANON = 2'd3
    } t_vstatus;

    typedef struct packed {
        t_vstatus          status;
        logic [ACC_W-1:0]  accum;
        logic [IDX_W-1:0]  index;
    } t_vstep;

    typedef struct packed {
        t_event             event_res;
        logic [FIELD_W-1:0] field_number;
        logic [WIRE_W-1:0]  wire_kind;
        logic [ACC_W-1:0]   field_value;
        logic [7:0]         payload_data;
        logic               payload_end;
        t_err               error_code;
        logic               message_done;
        logic               message_ok;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   error_seen;
    } t_status;

endpackage

[sv/pft_varint.sv]
// ============================================================================
// pft_varint: one byte step of the varint decoder
// Merges 7 bits (1 at index 9) into the accumulator, checks length and form.
// ============================================================================
module pft_varint (
    input  logic [pft_pkg::ACC_W-1:0] i_accum,
    input  logic [pft_pkg::IDX_W-1:0] i_index,
    input  logic [7:0]                i_byte,
    output pft_pkg::t_vstep           o_step
);

    logic [pft_pkg::IDX_W-1:0] idx;
    logic [pft_pkg::ACC_W-1:0] merged;
    logic                      at_last;

    always_comb begin
        at_last = (i_index >= pft_pkg::IDX_LAST);
        idx     = at_last ? pft_pkg::IDX_LAST : i_index;
        merged  = i_accum;
        for (int k = 0; k < 9; k++) begin
            if (idx == pft_pkg::IDX_W'(k)) begin
                merged[7*k +: 7] = i_accum[7*k +: 7] | i_byte[6:0];
            end
        end
        if (at_last) begin
            merged[pft_pkg::ACC_W-1] = i_accum[pft_pkg::ACC_W-1] | i_byte[0];
        end

        o_step.accum = merged;
        o_step.index = i_index;
        if (at_last && (i_byte[7:1] != 7'd0)) begin
            o_step.status = pft_pkg::VS_OVERFLOW;
            o_step.accum  = i_accum;
        end else if (!i_byte[7]) begin
            if ((idx != '0) && (i_byte[6:0] == 7'd0)) begin
                o_step.status = pft_pkg::VS_NONCANON;
            end else begin
                o_step.status = pft_pkg::VS_DONE;
            end
        end else begin
            o_step.status = pft_pkg::VS_MORE;
            o_step.index  = idx + 1'b1;
        end
    end

endmodule

[sv/pft_fsm.sv]
// ============================================================================
// pft_fsm: field parse state and per-byte result logic
// Tracks the parse phase and field context and forms the result of each byte.
// ============================================================================
module pft_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output pft_pkg::t_result   o_result,
    output pft_pkg::t_status   o_status
);

    pft_pkg::t_phase                   r_phase, n_phase;
    logic [pft_pkg::ACC_W-1:0]         r_accum, n_accum;
    logic [pft_pkg::IDX_W-1:0]         r_index, n_index;
    logic [pft_pkg::FIELD_W-1:0]       r_field, n_field;
    logic [pft_pkg::WIRE_W-1:0]        r_wire, n_wire;
    logic [pft_pkg::MSG_LEN_BITS-1:0]  r_left, n_left;
    logic                              r_err_seen, n_err_seen;

    pft_pkg::t_vstep                   vstep;
    logic [pft_pkg::ACC_W-1:0]         tval;
    logic [pft_pkg::MSG_LEN_BITS-1:0]  left_dec;
    pft_pkg::t_event                   ev;
    pft_pkg::t_err                     err;
    logic [pft_pkg::ACC_W-1:0]         val;
    logic [7:0]                        pd;
    logic                              pend;

    pft_varint u_varint (
        .i_accum (r_accum),
        .i_index (r_index),
        .i_byte  (i_byte),
        .o_step  (vstep)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= pft_pkg::PH_TAG;
            r_accum    <= '0;
            r_index    <= '0;
            r_field    <= '0;
            r_wire     <= '0;
            r_left     <= '0;
            r_err_seen <= 1'b0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_accum    <= n_accum;
            r_index    <= n_index;
            r_field    <= n_field;
            r_wire     <= n_wire;
            r_left     <= n_left;
            r_err_seen <= n_err_seen;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_accum    = r_accum;
        n_index    = r_index;
        n_field    = r_field;
        n_wire     = r_wire;
        n_left     = r_left;
        n_err_seen = r_err_seen;
        ev         = pft_pkg::EV_NONE;
        err        = pft_pkg::ERR_NONE;
        val        = '0;
        pd         = 8'd0;
        pend       = 1'b0;
        tval       = vstep.accum;
        left_dec   = (r_left != '0) ? (r_left - 1'b1) : r_left;

        case (r_phase)
            pft_pkg::PH_TAG, pft_pkg::PH_VALUE, pft_pkg::PH_LEN: begin
                n_accum = vstep.accum;
                n_index = vstep.index;
                case (vstep.status)
                    pft_pkg::VS_OVERFLOW, pft_pkg::VS_NONCANON: begin
                        if (r_phase == pft_pkg::PH_LEN) begin
                            err = pft_pkg::ERR_BAD_LEN;
                        end else if (vstep.status == pft_pkg::VS_OVERFLOW) begin
                            err = pft_pkg::ERR_OVERFLOW;
                        end else begin
                            err = pft_pkg::ERR_NONCANON;
                        end
                    end
                    pft_pkg::VS_DONE: begin
                        n_accum = '0;
                        n_index = '0;
                        if (r_phase == pft_pkg::PH_TAG) begin
                            n_field = tval[pft_pkg::FIELD_W+2:3];
                            n_wire  = tval[pft_pkg::WIRE_W-1:0];
                            if ((tval == '0) || (tval[pft_pkg::ACC_W-1:32] != '0)) begin
                                err = pft_pkg::ERR_BAD_TAG;
                            end else if (n_wire == pft_pkg::WIRE_VARINT) begin
                                n_phase = pft_pkg::PH_VALUE;
                            end else if (n_wire == pft_pkg::WIRE_LEN) begin
                                n_phase = pft_pkg::PH_LEN;
                            end else begin
                                err = pft_pkg::ERR_BAD_WIRE;
                            end
                        end else if (r_phase == pft_pkg::PH_VALUE) begin
                            ev      = pft_pkg::EV_VARINT;
                            val     = tval;
                            n_phase = pft_pkg::PH_TAG;
                        end else if (tval[pft_pkg::ACC_W-1:pft_pkg::MSG_LEN_BITS] != '0) begin
                            err = pft_pkg::ERR_BAD_LEN;
                        end else begin
                            ev      = pft_pkg::EV_HEADER;
                            val     = tval;
                            n_left  = tval[pft_pkg::MSG_LEN_BITS-1:0];
                            n_phase = (tval == '0) ? pft_pkg::PH_TAG : pft_pkg::PH_PAYLOAD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            pft_pkg::PH_PAYLOAD: begin
                ev     = pft_pkg::EV_PAYLOAD;
                pd     = i_byte;
                n_left = left_dec;
                if (left_dec == '0) begin
                    pend    = 1'b1;
                    n_phase = pft_pkg::PH_TAG;
                end
            end
            default: begin
            end
        endcase

        if ((err == pft_pkg::ERR_NONE) && i_last && (n_phase != pft_pkg::PH_SKIP) &&
            ((n_phase != pft_pkg::PH_TAG) || (n_index != '0))) begin
            if ((n_phase == pft_pkg::PH_TAG) || (n_phase == pft_pkg::PH_VALUE)) begin
                err = pft_pkg::ERR_TRUNC;
            end else begin
                err = pft_pkg::ERR_BAD_LEN;
            end
        end
        if (err != pft_pkg::ERR_NONE) begin
            ev         = pft_pkg::EV_ERROR;
            val        = '0;
            pd         = 8'd0;
            pend       = 1'b0;
            n_phase    = pft_pkg::PH_SKIP;
            n_err_seen = 1'b1;
        end

        o_result.event_res    = ev;
        o_result.field_number = n_field;
        o_result.wire_kind    = n_wire;
        o_result.field_value  = val;
        o_result.payload_data = pd;
        o_result.payload_end  = pend;
        o_result.error_code   = err;
        o_result.message_done = i_last;
        o_result.message_ok   = i_last && !n_err_seen;

        if (i_last) begin
            n_phase    = pft_pkg::PH_TAG;
            n_accum    = '0;
            n_index    = '0;
            n_field    = '0;
            n_wire     = '0;
            n_left     = '0;
            n_err_seen = 1'b0;
        end

        o_status.phase      = r_phase;
        o_status.error_seen = r_err_seen;
    end

endmodule

[sv/protobuf_field_tokenizer.sv]
// ============================================================================
// protobuf_field_tokenizer: streaming protobuf wire-format field splitter
// Takes message bytes on the slave stream and gives one result per byte.
// ============================================================================
// The tokenizer takes one message byte per cycle when the output is not
// stalled and returns exactly one result per byte, through the input
// register and then the result register. The rate is set by the update of
// the parse state (phase, varint accumulator, field context and payload
// count) between the input register and the result register; an output
// register lets a new byte enter while a finished result waits. tlast on
// the input marks the final byte of a message, and tlast on the output marks
// its result; all parse state returns to its start values after that byte.
module protobuf_field_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte
    input  logic          s_axis_tlast,   // last_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // field_number[28:0], wire_kind[31:29], field_value[95:32],
    // payload_data[103:96], payload_end[104], error_code[107:105],
    // message_ok[108], zero fill[111:109]
    output logic [111:0]  m_axis_tdata,
    output logic [2:0]    m_axis_tuser,   // event_res
    output logic          m_axis_tlast    // message_done
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    pft_pkg::t_result   r_out;
    pft_pkg::t_result   result;
    pft_pkg::t_status   status;
    logic               out_ready;
    logic               adv;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    pft_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result),
        .o_status (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.event_res;
    assign m_axis_tlast  = r_out.message_done;
    assign m_axis_tdata  = {3'b000, r_out.message_ok, r_out.error_code, r_out.payload_end,
                            r_out.payload_data, r_out.field_value, r_out.wire_kind,
                            r_out.field_number};

    a_skip_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.phase == pft_pkg::PH_SKIP |-> status.error_seen)
        else $error("skip phase without a recorded error");

    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> status.phase == pft_pkg::PH_TAG && !status.error_seen)
        else $error("parse state not cleared after final byte");

    a_error_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !r_in_last && result.event_res == pft_pkg::EV_ERROR
        |=> status.phase == pft_pkg::PH_SKIP)
        else $error("error did not enter skip phase");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |-> (result.event_res == pft_pkg::EV_ERROR) == (result.error_code != pft_pkg::ERR_NONE))
        else $error("error event and error code disagree");

endmodule

[dv/protobuf_field_tokenizer_tb.sv]
// ============================================================================
// protobuf_field_tokenizer_tb: self-checking bench for the field tokenizer
// Streams protobuf messages byte by byte into the tokenizer: a short list of
// hand-picked messages, then random messages, mostly well formed, some cut
// short and some carrying faulty varints, tags or lengths. A scoreboard
// decodes every accepted byte itself and checks each result transfer field
// by field. Both stream sides idle and stall at random.
// ============================================================================
module protobuf_field_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pft_pkg::*;

    localparam int              ITEMS       = 1850;
    localparam int              STALL_LIMIT = 5000;
    localparam logic [63:0]     FIELD_LIMIT = 64'd536870911;

    class token_scoreboard;
        t_result     due_tokens[$];
        int          fails = 0;
        int          n_checked = 0;
        int          n_taken = 0;
        int          n_msgs = 0;
        int          n_clean = 0;
        int          ev_tally[8];
        int          err_tally[8];
        t_phase      phase;
        logic [63:0] acc;
        logic [3:0]  idx;
        logic [28:0] cur_field;
        logic [2:0]  cur_wire;
        logic [63:0] left;
        bit          err_seen;

        function new();
            foreach (ev_tally[k]) ev_tally[k] = 0;
            foreach (err_tally[k]) err_tally[k] = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_TAG;
            acc = '0;
            idx = '0;
            cur_field = '0;
            cur_wire = '0;
            left = '0;
            err_seen = 1'b0;
        endfunction

        function t_vstatus take_varint(logic [7:0] b);
            logic [3:0] i;
            i = idx;
            if (i >= IDX_LAST) begin
                if (b[7:1] != 7'd0) begin
                    return VS_OVERFLOW;
                end
                i = IDX_LAST;
            end
            acc = acc | (64'(b[6:0]) << (7 * i));
            if (!b[7]) begin
                if (i > 0 && b[6:0] == 7'd0) begin
                    return VS_NONCANON;
                end
                return VS_DONE;
            end
            idx = i + 4'd1;
            return VS_MORE;
        endfunction

        // Decodes one accepted byte and queues the result it must produce.
        function void take_byte(logic [7:0] b, logic last);
            t_result     want;
            t_vstatus    r;
            t_err        err;
            logic [63:0] t;
            want = '0;
            want.event_res = EV_NONE;
            err = ERR_NONE;
            n_taken++;
            if (phase == PH_TAG || phase == PH_VALUE || phase == PH_LEN) begin
                r = take_varint(b);
                if (r == VS_OVERFLOW || r == VS_NONCANON) begin
                    if (phase == PH_LEN) begin
                        err = ERR_BAD_LEN;
                    end else if (r == VS_OVERFLOW) begin
                        err = ERR_OVERFLOW;
                    end else begin
                        err = ERR_NONCANON;
                    end
                end else if (r == VS_DONE) begin
                    t = acc;
                    acc = '0;
                    idx = '0;
                    case (phase)
                        PH_TAG: begin
                            cur_field = t[31:3];
                            cur_wire = t[2:0];
                            if (t == 64'd0 || (t >> 3) > FIELD_LIMIT) begin
                                err = ERR_BAD_TAG;
                            end else if (cur_wire == WIRE_VARINT) begin
                                phase = PH_VALUE;
                            end else if (cur_wire == WIRE_LEN) begin
                                phase = PH_LEN;
                            end else begin
                                err = ERR_BAD_WIRE;
                            end
                        end
                        PH_VALUE: begin
                            want.event_res = EV_VARINT;
                            want.field_value = t;
                            phase = PH_TAG;
                        end
                        default: begin
                            if ((t >> MSG_LEN_BITS) != 64'd0) begin
                                err = ERR_BAD_LEN;
                            end else begin
                                want.event_res = EV_HEADER;
                                want.field_value = t;
                                left = t;
                                phase = (t == 64'd0) ? PH_TAG : PH_PAYLOAD;
                            end
                        end
                    endcase
                end
            end else if (phase == PH_PAYLOAD) begin
                want.event_res = EV_PAYLOAD;
                want.payload_data = b;
                if (left > 0) begin
                    left--;
                end
                if (left == 0) begin
                    want.payload_end = 1'b1;
                    phase = PH_TAG;
                end
            end
            if (err == ERR_NONE && last && phase != PH_SKIP &&
                (phase != PH_TAG || idx != 0)) begin
                err = (phase == PH_TAG || phase == PH_VALUE) ? ERR_TRUNC : ERR_BAD_LEN;
            end
            if (err != ERR_NONE) begin
                want.event_res = EV_ERROR;
                want.field_value = '0;
                want.payload_data = '0;
                want.payload_end = 1'b0;
                phase = PH_SKIP;
                err_seen = 1'b1;
            end
            want.error_code = err;
            want.field_number = cur_field;
            want.wire_kind = cur_wire;
            want.message_done = last;
            want.message_ok = last && !err_seen;
            ev_tally[want.event_res]++;
            err_tally[err]++;
            due_tokens.insert(due_tokens.size(), want);
            if (last) begin
                n_msgs++;
                if (want.message_ok) begin
                    n_clean++;
                end
                clear();
            end
        endfunction

        function void differ(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                fails++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_token(t_result got);
            t_result want;
            if (due_tokens.size() == 0) begin
                fails++;
                $display("%0t: unexpected result transfer, expected none, got %h", $time, got);
                return;
            end
            want = due_tokens.pop_front();
            n_checked++;
            differ("event_res", want.event_res, got.event_res);
            differ("field_number", want.field_number, got.field_number);
            differ("wire_kind", want.wire_kind, got.wire_kind);
            differ("field_value", want.field_value, got.field_value);
            differ("payload_data", want.payload_data, got.payload_data);
            differ("payload_end", want.payload_end, got.payload_end);
            differ("error_code", want.error_code, got.error_code);
            differ("message_done", want.message_done, got.message_done);
            differ("message_ok", want.message_ok, got.message_ok);
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [7:0]     s_axis_tdata = 8'd0;    // data_byte
    logic           s_axis_tlast = 1'b0;    // last_byte
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    // field_number, wire_kind, field_value, payload_data, payload_end,
    // error_code, message_ok, zero fill
    logic [111:0]   m_axis_tdata;
    logic [2:0]     m_axis_tuser;           // event_res
    logic           m_axis_tlast;           // message_done

    token_scoreboard sb;
    t_result         observed;
    logic [7:0]      msg[$];
    bit              calm = 1'b0;
    int              idle_cycles = 0;

    protobuf_field_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_value();
        int          nb;
        logic [63:0] v;
        nb = $urandom_range(0, 64);
        v = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) begin
            return '1;
        end
        if (nb < 64) begin
            v = v & ((64'd1 << nb) - 64'd1);
        end
        return v;
    endfunction

    function automatic logic [28:0] rand_field();
        logic [28:0] f;
        case ($urandom_range(0, 5))
            0: f = 29'd1;
            1: f = '1;
            2: f = 29'($urandom_range(2, 15));
            3: f = 29'($urandom_range(16, 4095));
            default: f = 29'($urandom);
        endcase
        if (f == 29'd0) begin
            f = 29'd1;
        end
        return f;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        msg.insert(msg.size(), b);
    endfunction

    // Extra pad groups give a noncanonical encoding, or an overlong one.
    function automatic void put_varint(logic [63:0] v, int pad);
        while (v > 64'd127) begin
            put_byte({1'b1, v[6:0]});
            v = v >> 7;
        end
        put_byte({pad > 0, v[6:0]});
        for (int k = 1; k < pad; k++) begin
            put_byte(8'h80);
        end
        if (pad > 0) begin
            put_byte(8'h00);
        end
    endfunction

    function automatic void put_tag(logic [28:0] f, logic [2:0] w, int pad);
        put_varint({32'd0, f, w}, pad);
    endfunction

    function automatic void put_field();
        int len;
        if ($urandom_range(0, 1) == 1) begin
            put_tag(rand_field(), WIRE_VARINT, 0);
            put_varint(rand_value(), 0);
        end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
            put_tag(rand_field(), WIRE_LEN, 0);
            put_varint(64'(len), 0);
            repeat (len) put_byte(8'($urandom));
        end
    endfunction

    // Varint faults go into the tag, the value or the length position.
    function automatic void put_head(int pos);
        if (pos == 1) begin
            put_tag(rand_field(), WIRE_VARINT, 0);
        end else if (pos == 2) begin
            put_tag(rand_field(), WIRE_LEN, 0);
        end
    endfunction

    function automatic void put_fault();
        int          pos;
        int          k;
        logic [63:0] v;
        pos = $urandom_range(0, 2);
        case ($urandom_range(0, 7))
            0: repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
            1: begin
                k = $urandom_range(3, 8);
                put_tag(rand_field(), (k == 8) ? 3'd1 : 3'(k), 0);
            end
            2: put_varint(64'd0, 0);
            3: put_varint({$urandom, $urandom} | (64'd1 << $urandom_range(32, 63)), 0);
            4: begin
                put_head(pos);
                v = (pos == 0) ? {32'd0, rand_field(), WIRE_VARINT}
                               : 64'($urandom_range(0, 300));
                put_varint(v, $urandom_range(1, 3));
            end
            5: begin
                put_head(pos);
                repeat (9) put_byte({1'b1, 7'($urandom)});
                put_byte(8'($urandom_range(2, 255)));
            end
            6: begin
                put_tag(rand_field(), WIRE_LEN, 0);
                put_varint((64'd1 << $urandom_range(16, 63)) | 64'($urandom_range(0, 65535)), 0);
            end
            default: begin
                k = $urandom_range(5, 100);
                put_tag(rand_field(), WIRE_LEN, 0);
                put_varint(64'(k), 0);
                repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
            end
        endcase
    endfunction

    function automatic void build_msg();
        int mode;
        msg.delete();
        mode = $urandom_range(0, 9);
        if (mode < 8) begin
            repeat ($urandom_range(1, 4)) put_field();
            if (mode == 7) begin
                repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
            end
        end else begin
            repeat ($urandom_range(0, 3)) put_field();
            put_fault();
            repeat ($urandom_range(0, 2)) put_field();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_msg();
        foreach (msg[k]) begin
            send_byte(msg[k], k == msg.size() - 1);
        end
    endtask

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    hold = pick_gap();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.take_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                observed.event_res = t_event'(m_axis_tuser);
                observed.field_number = m_axis_tdata[28:0];
                observed.wire_kind = m_axis_tdata[31:29];
                observed.field_value = m_axis_tdata[95:32];
                observed.payload_data = m_axis_tdata[103:96];
                observed.payload_end = m_axis_tdata[104];
                observed.error_code = t_err'(m_axis_tdata[107:105]);
                observed.message_ok = m_axis_tdata[108];
                observed.message_done = m_axis_tlast;
                sb.check_token(observed);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-picked messages: a plain varint field, an empty and a short
        // bytes field, a missing value, a missing length, a zero tag, a bad wire
        // type, a noncanonical tag, a short payload and a padded length.
        msg = '{8'h08, 8'h96, 8'h01};
        send_msg();
        msg = '{8'h12, 8'h00, 8'h1a, 8'h02, 8'h00, 8'hff};
        send_msg();
        msg = '{8'h08};
        send_msg();
        msg = '{8'h0a};
        send_msg();
        msg = '{8'h00, 8'h55};
        send_msg();
        msg = '{8'h0f};
        send_msg();
        msg = '{8'h88, 8'h00, 8'h01};
        send_msg();
        msg = '{8'h12, 8'h05, 8'h01};
        send_msg();
        msg = '{8'h0a, 8'h80, 8'h00};
        send_msg();

        while (sb.n_taken < ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            build_msg();
            send_msg();
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.due_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Covered %0d messages (%0d clean), %0d results checked.",
                 sb.n_msgs, sb.n_clean, sb.n_checked);
        $display("Events none/varint/header/payload/error: %0d/%0d/%0d/%0d/%0d",
                 sb.ev_tally[EV_NONE], sb.ev_tally[EV_VARINT], sb.ev_tally[EV_HEADER],
                 sb.ev_tally[EV_PAYLOAD], sb.ev_tally[EV_ERROR]);
        if (sb.fails == 0 && sb.due_tokens.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
